// ===== sv/bfa_pkg.sv =====
// shared types, constants and helpers for the bitmap first-fit block allocator
package bfa_pkg;

    // bitmap word geometry
    localparam int WORD_W     = 8;
    localparam int WORD_SHIFT = 3;

    // configuration register indexes
    localparam logic REG_BLOCK_SIZE   = 1'b0;
    localparam logic REG_HEADER_BYTES = 1'b1;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NORUN   = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [26:0] FREE_MAX = 27'h7FF_FFFF;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_MUL,
        S_SCAN,
        S_MOD_RD,
        S_MOD_WR,
        S_RESP
    } state_t;

    // clamp a wide byte count to the free counter range
    function automatic logic [26:0] sat_free(input logic [34:0] v);
        return (v > {8'd0, FREE_MAX}) ? FREE_MAX : v[26:0];
    endfunction

endpackage

// ===== sv/bfa_bitmap_ram.sv =====
// occupancy bitmap storage, one write port and one registered read port
module bfa_bitmap_ram
    import bfa_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/bfa_divider.sv =====
// restoring divider, one quotient bit per cycle
module bfa_divider
    import bfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [26:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [26:0] quotient,
    output logic [16:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [26:0] quo_reg, quo_next;
    logic [16:0] den_reg, den_next;
    logic [17:0] rem_reg, rem_next;
    logic [17:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg[16:0], quo_reg[26]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            quo_next  = dividend;
            den_next  = divisor;
            rem_next  = 18'd0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[25:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[25:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd26)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[16:0];

endmodule

// ===== sv/bitmap_first_fit_block_allocator.sv =====
// top level of the bitmap first-fit block allocator
// A pool of NUM_BLOCKS equal blocks is tracked by an occupancy bitmap held in
// a synchronous RAM of 8-bit words, plus a 27-bit free byte counter. An
// allocate request (tuser 0) adds header_bytes to alloc_bytes, divides by the
// block size (rounded up) in a bit-serial divider of 27 steps, then scans the
// bitmap from block 0 one word per cycle for the lowest run of free blocks
// long enough, and marks it taken with a read-modify-write of each bitmap
// word touched. A free request (tuser 1) skips the divide and scan and
// clears its run the same way. Requests that fail early (not enough space,
// out of range) go straight to loading their result. An allocate passes
// through the divider, the block product, the scan, the marking of each
// word and the loading of the result; a free passes through the block
// product, the clearing of each word and the loading of the result. One
// request is in flight at a time; the result sits in an output register so
// the next request can be taken while it waits. After reset, and after every
// write of block_size, a clearing pass zeroes the bitmap and the free count
// is reloaded with NUM_BLOCKS * block_size; no request is taken meanwhile.
// A block_size of 0 acts as 1. Configuration must be written only while
// idle; the block itself does not enforce it. NUM_BLOCKS ranges from 8 to
// 1024.
module bitmap_first_fit_block_allocator
    import bfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [16:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // alloc_bytes[25:0], free_start_block[35:26], free_block_count[46:36], pad
    input  logic [47:0] s_tdata,
    // action[0]
    input  logic [0:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], start_block[11:2], block_count[22:12], free_bytes[49:23], pad
    output logic [55:0] m_tdata
);

    localparam int DEPTH = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(NUM_BLOCKS + 1);
    localparam int IW    = $clog2(NUM_BLOCKS);
    localparam int XW    = AW + WORD_SHIFT;
    localparam logic [33:0] RST_PROD = 34'(NUM_BLOCKS) * 34'd64;
    localparam logic [26:0] RST_FREE = sat_free({1'b0, RST_PROD});

    state_t state_reg, state_next;

    logic [16:0] bs_reg, bs_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [26:0] free_reg, free_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic        op_reg, op_next;
    logic [1:0]  status_reg, status_next;
    logic [9:0]  res_start_reg, res_start_next;
    logic [10:0] res_count_reg, res_count_next;
    logic [CW-1:0] blocks_reg, blocks_next;
    logic [IW-1:0] rstart_reg, rstart_next;
    logic [CW-1:0] end_reg, end_next;
    logic [CW-1:0] run_reg, run_next;
    logic [IW-1:0] run_start_reg, run_start_next;
    logic [AW:0]   scan_rd_reg, scan_rd_next;
    logic          rvalid_reg, rvalid_next;
    logic [AW-1:0] eval_addr_reg, eval_addr_next;
    logic [AW-1:0] mod_addr_reg, mod_addr_next;
    logic [AW-1:0] last_addr_reg, last_addr_next;
    logic [16:0]   mul_a_reg, mul_a_next;
    logic [33:0]   prod_reg, prod_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [55:0]   m_tdata_reg, m_tdata_next;

    // derived values
    logic [16:0] eff_bs;
    logic [16:0] cfg_eff;
    logic [33:0] cfg_prod;
    logic [26:0] need;
    logic [9:0]  in_start;
    logic [10:0] in_count;
    logic [17:0] in_end;
    logic [27:0] blocks_wide;
    logic [CW:0] found_end;
    logic [CW-1:0] last_blk;

    // scan word evaluation
    logic [CW-1:0] ev_run;
    logic [IW-1:0] ev_st;
    logic          ev_found;
    logic [IW-1:0] ev_fs;
    logic [XW-1:0] ev_bx;
    logic          ev_occ;

    // modify word evaluation
    logic [WORD_W-1:0] mod_mask;
    logic [XW-1:0]     mod_bx;

    // ram and divider hookups
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              div_start;
    logic              div_done;
    logic [26:0]       div_q;
    logic [16:0]       div_r;

    bfa_bitmap_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (need),
        .divisor   (eff_bs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign eff_bs   = (bs_reg == 17'd0) ? 17'd1 : bs_reg;
    assign cfg_eff  = (cfg_data == 17'd0) ? 17'd1 : cfg_data;
    assign cfg_prod = 34'(NUM_BLOCKS) * {17'd0, cfg_eff};
    assign need     = {1'b0, s_tdata[25:0]} + {19'd0, hdr_reg};
    assign in_start = s_tdata[35:26];
    assign in_count = s_tdata[46:36];
    assign in_end   = {8'd0, in_start} + {7'd0, in_count};
    assign blocks_wide = {1'b0, div_q} + {27'd0, (div_r != 17'd0)};

    // walk one bitmap word, carrying the free run in from the word before
    always_comb
    begin
        ev_run   = run_reg;
        ev_st    = run_start_reg;
        ev_found = 1'b0;
        ev_fs    = '0;
        ev_bx    = '0;
        ev_occ   = 1'b0;
        for (int j = 0; j < WORD_W; j++)
        begin
            ev_bx  = {eval_addr_reg, WORD_SHIFT'(j)};
            ev_occ = ram_rdata[j] || (32'(ev_bx) >= NUM_BLOCKS);
            if (!ev_found)
            begin
                if (ev_occ)
                begin
                    ev_run = '0;
                end
                else
                begin
                    if (ev_run == '0)
                    begin
                        ev_st = IW'(ev_bx);
                    end
                    ev_run = ev_run + CW'(1);
                    if (ev_run == blocks_reg)
                    begin
                        ev_found = 1'b1;
                        ev_fs    = ev_st;
                    end
                end
            end
        end
    end

    // bits of the current word that fall inside the run being marked or cleared
    always_comb
    begin
        mod_mask = '0;
        mod_bx   = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            mod_bx      = {mod_addr_reg, WORD_SHIFT'(j)};
            mod_mask[j] = (32'(mod_bx) >= 32'(rstart_reg)) && (32'(mod_bx) < 32'(end_reg));
        end
    end

    assign found_end = {1'b0, CW'(ev_fs)} + {1'b0, blocks_reg};
    assign last_blk  = end_reg - CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        bs_next        = bs_reg;
        hdr_next       = hdr_reg;
        free_next      = free_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        res_start_next = res_start_reg;
        res_count_next = res_count_reg;
        blocks_next    = blocks_reg;
        rstart_next    = rstart_reg;
        end_next       = end_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        scan_rd_next   = scan_rd_reg;
        rvalid_next    = 1'b0;
        eval_addr_next = eval_addr_reg;
        mod_addr_next  = mod_addr_reg;
        last_addr_next = last_addr_reg;
        mul_a_next     = mul_a_reg;
        prod_next      = prod_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        div_start      = 1'b0;
        s_tready       = (state_reg == S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next        = s_tuser[0];
                    res_start_next = 10'd0;
                    res_count_next = 11'd0;
                    if (s_tuser[0] == ACT_ALLOC)
                    begin
                        if (free_reg < need)
                        begin
                            status_next = ST_NOSPACE;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        if (in_count == 11'd0 || 32'(in_end) > NUM_BLOCKS)
                        begin
                            status_next = ST_RANGE;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            status_next    = ST_OK;
                            rstart_next    = IW'(in_start);
                            end_next       = CW'(in_end);
                            mul_a_next     = 17'(in_count);
                            res_start_next = in_start;
                            res_count_next = in_count;
                            state_next     = S_MUL;
                        end
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    if (blocks_wide == 28'd0 || 32'(blocks_wide) > NUM_BLOCKS)
                    begin
                        status_next = ST_NORUN;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        blocks_next = CW'(blocks_wide);
                        mul_a_next  = 17'(blocks_wide);
                        state_next  = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                prod_next      = {17'd0, mul_a_reg} * {17'd0, eff_bs};
                scan_rd_next   = '0;
                run_next       = '0;
                run_start_next = '0;
                mod_addr_next  = AW'(rstart_reg >> WORD_SHIFT);
                last_addr_next = AW'(last_blk >> WORD_SHIFT);
                state_next     = (op_reg == ACT_ALLOC) ? S_SCAN : S_MOD_RD;
            end

            S_SCAN:
            begin
                // reads run one word ahead of the evaluation
                if (32'(scan_rd_reg) < DEPTH)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = scan_rd_reg[AW-1:0];
                    scan_rd_next   = scan_rd_reg + (AW+1)'(1);
                    rvalid_next    = 1'b1;
                    eval_addr_next = scan_rd_reg[AW-1:0];
                end
                if (rvalid_reg)
                begin
                    run_next       = ev_run;
                    run_start_next = ev_st;
                    if (ev_found)
                    begin
                        rvalid_next    = 1'b0;
                        status_next    = ST_OK;
                        rstart_next    = ev_fs;
                        end_next       = CW'(found_end);
                        res_start_next = 10'(ev_fs);
                        res_count_next = 11'(blocks_reg);
                        mod_addr_next  = AW'(ev_fs >> WORD_SHIFT);
                        last_addr_next = AW'((CW'(found_end) - CW'(1)) >> WORD_SHIFT);
                        state_next     = S_MOD_RD;
                    end
                    else if (eval_addr_reg == AW'(DEPTH - 1))
                    begin
                        rvalid_next = 1'b0;
                        status_next = ST_NORUN;
                        state_next  = S_RESP;
                    end
                end
            end

            S_MOD_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = mod_addr_reg;
                state_next = S_MOD_WR;
            end

            S_MOD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = mod_addr_reg;
                ram_wdata = (op_reg == ACT_ALLOC) ? (ram_rdata | mod_mask)
                                                  : (ram_rdata & ~mod_mask);
                if (mod_addr_reg == last_addr_reg)
                begin
                    if (op_reg == ACT_ALLOC)
                    begin
                        free_next = (prod_reg > {7'd0, free_reg}) ? 27'd0
                                                                  : free_reg - prod_reg[26:0];
                    end
                    else
                    begin
                        free_next = sat_free({8'd0, free_reg} + {1'b0, prod_reg});
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    mod_addr_next = mod_addr_reg + AW'(1);
                    state_next    = S_MOD_RD;
                end
            end

            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, free_reg, res_count_reg, res_start_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes, made only while idle by the user (not enforced)
        if (cfg_we)
        begin
            if (cfg_addr[0] == REG_BLOCK_SIZE)
            begin
                bs_next       = cfg_data;
                free_next     = sat_free({1'b0, cfg_prod});
                clr_addr_next = '0;
                state_next    = S_CLEAR;
            end
            else
            begin
                hdr_next = cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            bs_reg        <= 17'd64;
            hdr_reg       <= 8'd16;
            free_reg      <= RST_FREE;
            clr_addr_reg  <= '0;
            rvalid_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bs_reg        <= bs_next;
            hdr_reg       <= hdr_next;
            free_reg      <= free_next;
            clr_addr_reg  <= clr_addr_next;
            rvalid_reg    <= rvalid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        status_reg    <= status_next;
        res_start_reg <= res_start_next;
        res_count_reg <= res_count_next;
        blocks_reg    <= blocks_next;
        rstart_reg    <= rstart_next;
        end_reg       <= end_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        scan_rd_reg   <= scan_rd_next;
        eval_addr_reg <= eval_addr_next;
        mod_addr_reg  <= mod_addr_next;
        last_addr_reg <= last_addr_next;
        mul_a_reg     <= mul_a_next;
        prod_reg      <= prod_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/bfa_checker.sv =====
// port-level checks for the allocator, bound to the top level
module bfa_checker
    import bfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // failed requests report no run
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[11:2] == 10'd0 && m_tdata[22:12] == 11'd0)
        else $error("error result carries a run");

    // good results always cover blocks
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_OK |-> m_tdata[22:12] != 11'd0 && m_tdata[55:50] == 6'd0)
        else $error("good result with empty run");

endmodule

bind bitmap_first_fit_block_allocator bfa_checker u_bfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
